/* sv/rmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rmc_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int TAG_BITS_DEF = 32;

  localparam int ID_W       = 32;
  localparam int CAP_W      = 5;
  localparam int SEED_W     = 16;
  localparam int SLOT_W     = 4;
  localparam int MISS_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 72;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 4'd0,
    REG_RANDOM_SEED = 4'd1
  } cfg_reg_e;

  // result word, hit in bit 0
  typedef struct packed {
    logic              pad;
    logic [MISS_W-1:0] miss_count;
    logic              phase_reset;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   victim_id;
    logic              evicted;
    logic              hit;
  } result_t;

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/randomized_marking_cache_replacement.sv */
// Randomized marking replacement over a fully associative tag store.
// Request channel s_axis: tdata carries object_id. Result channel m_axis:
// tdata carries hit, evicted, victim_id, slot, phase_reset, miss_count.
// Configuration channel cfg: index 0 writes capacity, index 1 writes the
// random seed and reloads the victim LFSR at once; cfg_ready_o is always high.
// Write configuration only while no request is in flight.
// Flow: a request is held in the input register; lookup, victim pick and
// state update are combinational from it, and the result is captured in the
// result register when the output is free. Throughput: one request per cycle
// while m_axis_tready is high, set by the combinational tag compare and
// rotating priority pick; the LFSR start slot is computed a step ahead.
// When m_axis_tready is low the result register holds its transaction and
// the input register can still take one more request, then s_axis_tready
// drops until the result is taken.
// Reset clears all valid and mark bits, counters, capacity to 16 and
// the LFSR to 1; no sweep is needed and requests are taken right away.
`timescale 1ns / 1ps
`default_nettype none

module randomized_marking_cache_replacement #(
  parameter int ENTRIES  = rmc_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = rmc_pkg::TAG_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [rmc_pkg::ID_W-1:0]       s_axis_tdata,  // object_id
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // hit, evicted, victim_id, slot, phase_reset, miss_count, zero pad
  output logic [rmc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMPW  = (CNT_W > rmc_pkg::CAP_W) ? CNT_W : rmc_pkg::CAP_W;
  localparam int ID_W  = rmc_pkg::ID_W;

  logic                        in_valid_q;
  logic [TAG_BITS-1:0]         in_tag_q;
  logic [TAG_BITS+ID_W-1:0]    id_ext;
  logic                        out_valid_q;
  rmc_pkg::result_t            out_q, res;
  logic [rmc_pkg::CAP_W-1:0]   cap_q;
  logic [ENTRIES-1:0]          valid_q, valid_d;
  logic [ENTRIES-1:0]          mark_q, mark_d;
  logic [CNT_W-1:0]            occ_q, occ_d;
  logic [CNT_W-1:0]            mc_q, mc_d;
  logic [rmc_pkg::MISS_W-1:0]  misses_q, misses_d;

  logic                        advance;
  logic [CMPW-1:0]             cap_eff;
  logic                        hit;
  logic [IDX_W-1:0]            hit_idx, free_idx, victim_idx, start, pos;
  logic [TAG_BITS-1:0]         rd_tag;
  logic [TAG_BITS+ID_W-1:0]    rd_ext;
  logic [IDX_W+rmc_pkg::SLOT_W-1:0] pos_ext;
  logic                        pick;
  logic                        ev;
  logic                        phase;
  logic                        seed_load;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign seed_load     = cfg_valid_i &&
                         (rmc_pkg::cfg_reg_e'(cfg_index_i) == rmc_pkg::REG_RANDOM_SEED);
  assign id_ext        = {{TAG_BITS{1'b0}}, s_axis_tdata};

  always_comb begin
    cap_eff = CMPW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMPW'(1);
    end
    if (cap_eff > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end
  end

  rmc_tag_match #(
    .ENTRIES (ENTRIES),
    .TAG_BITS(TAG_BITS)
  ) u_match (
    .clk_i       (clk_i),
    .valid_i     (valid_q),
    .lookup_tag_i(in_tag_q),
    .rd_idx_i    (victim_idx),
    .wr_en_i     (advance && !hit),
    .wr_idx_i    (pos),
    .wr_tag_i    (in_tag_q),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx),
    .free_idx_o  (free_idx),
    .rd_tag_o    (rd_tag)
  );

  rmc_victim_pick #(
    .ENTRIES(ENTRIES)
  ) u_pick (
    .valid_i (valid_q),
    .mark_i  (mark_q),
    .start_i (start),
    .victim_o(victim_idx)
  );

  rmc_start_gen #(
    .ENTRIES(ENTRIES)
  ) u_start (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (seed_load),
    .seed_i (cfg_data_i[rmc_pkg::SEED_W-1:0]),
    .step_i (advance && pick),
    .start_o(start)
  );

  always_comb begin
    pick     = !hit && (CMPW'(occ_q) >= cap_eff);
    pos      = hit ? hit_idx : (pick ? victim_idx : free_idx);
    ev       = pick && valid_q[pos];
    valid_d  = valid_q;
    mark_d   = mark_q;
    occ_d    = occ_q;
    mc_d     = mc_q;
    misses_d = misses_q;
    if (hit) begin
      if (!mark_q[pos]) begin
        mark_d[pos] = 1'b1;
        mc_d        = mc_q + 1'b1;
      end
    end else begin
      misses_d = misses_q + 1'b1;
      if (ev && mark_q[pos] && (mc_d != '0)) begin
        mc_d = mc_d - 1'b1;
      end
      mc_d         = mc_d + 1'b1;
      valid_d[pos] = 1'b1;
      mark_d[pos]  = 1'b1;
      if (!ev) begin
        occ_d = occ_q + 1'b1;
      end
    end
    phase = (CMPW'(mc_d) >= cap_eff);
    if (phase) begin
      mark_d = '0;
      mc_d   = '0;
    end
  end

  always_comb begin
    rd_ext          = {{ID_W{1'b0}}, rd_tag};
    pos_ext         = {{rmc_pkg::SLOT_W{1'b0}}, pos};
    res             = '0;
    res.hit         = hit;
    res.evicted     = ev;
    res.victim_id   = ev ? rd_ext[ID_W-1:0] : '0;
    res.slot        = pos_ext[rmc_pkg::SLOT_W-1:0];
    res.phase_reset = phase;
    res.miss_count  = misses_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= rmc_pkg::CAP_RESET;
      valid_q     <= '0;
      mark_q      <= '0;
      occ_q       <= '0;
      mc_q        <= '0;
      misses_q    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (rmc_pkg::cfg_reg_e'(cfg_index_i))
          rmc_pkg::REG_CAPACITY: begin
            cap_q <= cfg_data_i[rmc_pkg::CAP_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (advance) begin
        valid_q  <= valid_d;
        mark_q   <= mark_d;
        occ_q    <= occ_d;
        mc_q     <= mc_d;
        misses_q <= misses_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tag_q <= id_ext[TAG_BITS-1:0];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CNT_W'($countones(valid_q)))
    else $error("occupancy out of step with valid bits");

  a_mark_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mc_q == CNT_W'($countones(mark_q)))
    else $error("marked count out of step with mark bits");

  a_phase_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase) |=> (mark_q == '0))
    else $error("marks not cleared after phase reset");

  a_miss_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !hit) |=> (misses_q == $past(misses_q) + 1'b1))
    else $error("miss counter did not advance on a miss");

  a_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_q & ~valid_q) == '0)
    else $error("mark set on an invalid entry");

endmodule

`default_nettype wire

/* sv/rmc_tag_match.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmc_tag_match #(
  parameter int ENTRIES  = rmc_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = rmc_pkg::TAG_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic [ENTRIES-1:0]         valid_i,
  input  wire logic [TAG_BITS-1:0]        lookup_tag_i,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_idx_i,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(ENTRIES)-1:0] wr_idx_i,
  input  wire logic [TAG_BITS-1:0]        wr_tag_i,
  output logic                            hit_o,
  output logic [$clog2(ENTRIES)-1:0]      hit_idx_o,
  output logic [$clog2(ENTRIES)-1:0]      free_idx_o,
  output logic [TAG_BITS-1:0]             rd_tag_o
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [TAG_BITS-1:0] tag_q [ENTRIES];
  logic [ENTRIES-1:0]  match;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_q[wr_idx_i] <= wr_tag_i;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_i[i] && (tag_q[i] == lookup_tag_i);
    end
  end

  always_comb begin
    hit_o      = |match;
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_o = IDX_W'(i);
      end
      if (!valid_i[i]) begin
        free_idx_o = IDX_W'(i);
      end
    end
  end

  assign rd_tag_o = tag_q[rd_idx_i];

endmodule

`default_nettype wire

/* sv/rmc_victim_pick.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmc_victim_pick #(
  parameter int ENTRIES = rmc_pkg::ENTRIES_DEF
) (
  input  wire logic [ENTRIES-1:0]         valid_i,
  input  wire logic [ENTRIES-1:0]         mark_i,
  input  wire logic [$clog2(ENTRIES)-1:0] start_i,
  output logic [$clog2(ENTRIES)-1:0]      victim_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W:0] DEPTH = (IDX_W + 1)'(ENTRIES);

  logic [ENTRIES-1:0] cand;
  logic [ENTRIES-1:0] rot;
  logic [IDX_W:0]     sum;
  logic [IDX_W:0]     off;
  logic               found;

  always_comb begin
    cand = valid_i & ~mark_i;
    if (cand == '0) begin
      cand = valid_i;
    end
    // rotate so that the start slot sits at position zero
    for (int i = 0; i < ENTRIES; i++) begin
      sum = {1'b0, start_i} + (IDX_W + 1)'(i);
      if (sum >= DEPTH) begin
        sum = sum - DEPTH;
      end
      rot[i] = cand[sum[IDX_W-1:0]];
    end
    found = |rot;
    off   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (rot[i]) begin
        off = (IDX_W + 1)'(i);
      end
    end
    sum = {1'b0, start_i} + off;
    if (sum >= DEPTH) begin
      sum = sum - DEPTH;
    end
    victim_o = found ? sum[IDX_W-1:0] : start_i;
  end

endmodule

`default_nettype wire

/* sv/rmc_start_gen.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmc_start_gen #(
  parameter int ENTRIES = rmc_pkg::ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic [rmc_pkg::SEED_W-1:0] seed_i,
  input  wire logic                       step_i,
  output logic [$clog2(ENTRIES)-1:0]      start_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [rmc_pkg::SEED_W-1:0] RST_NEXT = rmc_pkg::lfsr_step(rmc_pkg::SEED_RESET);
  localparam logic [IDX_W-1:0] START_RESET = IDX_W'(RST_NEXT % ENTRIES);

  logic [rmc_pkg::SEED_W-1:0] lfsr_q, lfsr_d;
  logic [rmc_pkg::SEED_W-1:0] ahead;
  logic [IDX_W-1:0]           start_q, start_d;

  always_comb begin
    lfsr_d = lfsr_q;
    if (load_i) begin
      lfsr_d = (seed_i == '0) ? rmc_pkg::SEED_RESET : seed_i;
    end else if (step_i) begin
      lfsr_d = rmc_pkg::lfsr_step(lfsr_q);
    end
    ahead = rmc_pkg::lfsr_step(lfsr_d);
  end

  // start slot for the next pick, kept one step ahead
  if ((1 << IDX_W) == ENTRIES) begin : g_pow2
    assign start_d = ahead[IDX_W-1:0];
  end else begin : g_recip
    localparam int K = rmc_pkg::SEED_W + IDX_W;
    localparam logic [33:0] MREC = 34'(((64'd1 << K) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
    logic [33:0]                prod;
    logic [rmc_pkg::SEED_W-1:0] quo;
    logic [23:0]                qn;
    logic [rmc_pkg::SEED_W-1:0] rem;
    always_comb begin
      prod    = 34'(ahead) * MREC;
      quo     = rmc_pkg::SEED_W'(prod >> K);
      qn      = 24'(quo) * 24'(ENTRIES);
      rem     = ahead - qn[rmc_pkg::SEED_W-1:0];
      start_d = rem[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q  <= rmc_pkg::SEED_RESET;
      start_q <= START_RESET;
    end else begin
      lfsr_q  <= lfsr_d;
      start_q <= start_d;
    end
  end

  assign start_o = start_q;

endmodule

`default_nettype wire
